// File: hw/rtl/crst_pkg.sv
// Shared types, constants and a helper function for the RTC/SNTP timekeeper.
package crst_pkg;

   // Width of the RTC hardware counter, from 16 to 32 bits.
   localparam int RTC_COUNTER_BITS = 32;

   // Width of the nanoseconds-per-count scale and of the raw product.
   localparam int SCALE_W = 22;
   localparam int PROD_W  = RTC_COUNTER_BITS + SCALE_W;

   // Divider sizing: a 64-bit dividend over a divisor below 2^30.
   localparam int DIV_W   = 64;
   localparam int DVSR_W  = 30;

   // Reciprocals floor(2^64 / divisor) for the two divisors.
   localparam logic [63:0] RECIP_NS = 64'h0000_0004_4B82_FA09;
   localparam logic [63:0] RECIP_DS = 64'h1999_9999_9999_9999;

   // Time constants.
   localparam logic [63:0]         NTP_UNIX_OFFSET  = 64'd2208988800;
   localparam logic [DVSR_W-1:0]   NS_PER_SECOND    = 30'd1000000000;
   localparam logic [DVSR_W-1:0]   DS_PER_SECOND    = 30'd10;
   localparam logic [9:0]          NS_PER_US        = 10'd1000;
   localparam logic signed [16:0]  SECONDS_PER_HOUR = 17'sd3600;

   // Reset values of the poll reload registers.
   localparam logic [15:0] BURST_POLL_RESET   = 16'd50;
   localparam logic [15:0] REGULAR_POLL_RESET = 16'd6000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SNTP_ENABLED   = 2'd0;
   localparam logic [1:0] CSR_TIMEZONE_HOURS = 2'd1;
   localparam logic [1:0] CSR_BURST_POLL     = 2'd2;
   localparam logic [1:0] CSR_REGULAR_POLL   = 2'd3;

   // Item modes.
   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_REPLY   = 2'd1,
      MODE_STAMP   = 2'd2,
      MODE_RESTART = 2'd3
   } crst_mode_type;

   // Control from the sequencer to the divider.
   typedef struct packed {
      logic start;
      logic use_ns;
   } crst_div_ctl_type;

   // Status from the divider back to the sequencer.
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } crst_div_rsp_type;

   // Timezone offset in seconds, sign-extended to 64 bits.
   function automatic logic [63:0] crst_tz_seconds(input logic signed [4:0] tz);
      logic signed [16:0] prod;
      prod = 17'(tz) * SECONDS_PER_HOUR;
      return 64'(prod);
   endfunction

endpackage

// File: hw/rtl/calibrated_rtc_sntp_timekeeper_top.sv
// Top level of the RTC/SNTP timekeeper: state, sequencer and handshakes.
//
//   Port group   Direction  Handshake             Carries
//   req_*        in         req_valid/req_ready   one time event item
//   rsp_*        out        rsp_valid/rsp_ready   one result item per event
//   csr_*        in         csr_we                register index and data
//
// The result of an item comes from the seven-step reciprocal division on the shared
// multiplier (by one billion for the RTC source, by ten for the SNTP source); a tick
// first adds three steps to scale and accumulate the counter difference.
// Reset is synchronous and clears all time state and the output valid flag.
// Only one item is at work at a time; the next one can be taken as soon as the
// result sits in the output register, even while that register is still stalled.
module calibrated_rtc_sntp_timekeeper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_rtc_count,
   input  logic [23:0] req_rtc_cal,
   input  logic [31:0] req_ntp_seconds,
   input  logic        req_reply_valid,
   input  logic [63:0] req_new_stamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_stamp_seconds,
   output logic        rsp_source_sntp,
   output logic        rsp_send_request,
   output logic [31:0] rsp_requests_sent,
   output logic [31:0] rsp_replies_received,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MUL,
      ST_ACCUM,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam int RB = crst_pkg::RTC_COUNTER_BITS;

   state_type                       state_ff, state_in;

   // Configuration registers.
   logic                            sntp_en_ff, sntp_en_in;
   logic signed [4:0]               tz_ff, tz_in;
   logic [15:0]                     burst_ff, burst_in;
   logic [15:0]                     regular_ff, regular_in;

   // Time state.
   logic [RB-1:0]                   rtc_last_ff, rtc_last_in;
   logic [63:0]                     ns_total_ff, ns_total_in;
   logic [31:0]                     wrap_cnt_ff, wrap_cnt_in;
   logic [63:0]                     time_base_ff, time_base_in;
   logic [63:0]                     sntp_base_ff, sntp_base_in;
   logic [63:0]                     ds_ff, ds_in;
   logic [15:0]                     poll_wait_ff, poll_wait_in;
   logic                            regular_mode_ff, regular_mode_in;
   logic [31:0]                     sent_ff, sent_in;
   logic [31:0]                     recv_ff, recv_in;

   // Per-item working registers.
   logic                            send_ff, send_in;
   logic                            from_sntp_ff, from_sntp_in;
   logic [23:0]                     cal_ff, cal_in;
   logic [RB-1:0]                   diff_ff, diff_in;
   logic [crst_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [crst_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [63:0]                     base_sel_ff, base_sel_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [63:0]                     rsp_stamp_ff, rsp_stamp_in;
   logic                            rsp_source_ff, rsp_source_in;
   logic                            rsp_send_ff, rsp_send_in;
   logic [31:0]                     rsp_sent_ff, rsp_sent_in;
   logic [31:0]                     rsp_recv_ff, rsp_recv_in;

   logic [RB-1:0]                   sample;
   logic [33:0]                     cal_x;
   logic                            accept;
   logic                            out_free;
   crst_pkg::crst_div_ctl_type      div_ctl;
   logic [crst_pkg::DIV_W-1:0]      div_dividend;
   crst_pkg::crst_div_rsp_type      div_rsp;

   assign sample    = req_rtc_count[RB-1:0];
   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cal_x     = 34'(cal_ff) * 34'(crst_pkg::NS_PER_US);

   crst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .rsp      (div_rsp)
   );

   // Sequencer and next-state logic for all registers.
   always_comb begin
      state_in        = state_ff;
      sntp_en_in      = sntp_en_ff;
      tz_in           = tz_ff;
      burst_in        = burst_ff;
      regular_in      = regular_ff;
      rtc_last_in     = rtc_last_ff;
      ns_total_in     = ns_total_ff;
      wrap_cnt_in     = wrap_cnt_ff;
      time_base_in    = time_base_ff;
      sntp_base_in    = sntp_base_ff;
      ds_in           = ds_ff;
      poll_wait_in    = poll_wait_ff;
      regular_mode_in = regular_mode_ff;
      sent_in         = sent_ff;
      recv_in         = recv_ff;
      send_in         = send_ff;
      from_sntp_in    = from_sntp_ff;
      cal_in          = cal_ff;
      diff_in         = diff_ff;
      scale_in        = scale_ff;
      prod_in         = prod_ff;
      base_sel_in     = base_sel_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_stamp_in    = rsp_stamp_ff;
      rsp_source_in   = rsp_source_ff;
      rsp_send_in     = rsp_send_ff;
      rsp_sent_in     = rsp_sent_ff;
      rsp_recv_in     = rsp_recv_ff;
      div_ctl.start   = 1'b0;
      div_ctl.use_ns  = 1'b0;
      div_dividend    = ns_total_ff;

      // Register writes; the user must issue these only while the block is idle; the block does not enforce this.
      if (csr_we) begin
         case (csr_index)
            crst_pkg::CSR_SNTP_ENABLED:   sntp_en_in = csr_wdata[0];
            crst_pkg::CSR_TIMEZONE_HOURS: tz_in      = csr_wdata[4:0];
            crst_pkg::CSR_BURST_POLL:     burst_in   = csr_wdata;
            crst_pkg::CSR_REGULAR_POLL:   regular_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               send_in  = 1'b0;
               state_in = ST_PREP;
               case (req_mode)
                  crst_pkg::MODE_TICK: begin
                     // Counter difference; modular subtract covers the wrap.
                     diff_in     = sample - rtc_last_ff;
                     rtc_last_in = sample;
                     cal_in      = req_rtc_cal;
                     if (sample < rtc_last_ff) begin
                        wrap_cnt_in = wrap_cnt_ff + 1'b1;
                     end
                     // Request pacing and the decisecond count.
                     if (sntp_en_ff) begin
                        ds_in = ds_ff + 1'b1;
                        if (poll_wait_ff == '0) begin
                           send_in      = 1'b1;
                           sent_in      = sent_ff + 1'b1;
                           poll_wait_in = regular_mode_ff ? regular_ff : burst_ff;
                        end else begin
                           poll_wait_in = poll_wait_ff - 1'b1;
                        end
                     end
                     state_in = ST_SCALE;
                  end
                  crst_pkg::MODE_REPLY: begin
                     if (req_reply_valid) begin
                        recv_in         = recv_ff + 1'b1;
                        regular_mode_in = 1'b1;
                        sntp_base_in    = 64'(req_ntp_seconds) - crst_pkg::NTP_UNIX_OFFSET;
                        ds_in           = '0;
                     end
                  end
                  crst_pkg::MODE_STAMP: begin
                     time_base_in = req_new_stamp;
                     rtc_last_in  = sample;
                     ns_total_in  = '0;
                     wrap_cnt_in  = '0;
                  end
                  default: begin
                     ds_in           = '0;
                     sntp_base_in    = '0;
                     regular_mode_in = 1'b0;
                     poll_wait_in    = '0;
                     sent_in         = '0;
                     recv_in         = '0;
                  end
               endcase
            end
         end
         ST_SCALE: begin
            // Nanoseconds per counter step from the 12-bit fraction period.
            scale_in = cal_x[33:12];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = crst_pkg::PROD_W'(diff_ff) * crst_pkg::PROD_W'(scale_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            ns_total_in = ns_total_ff + 64'(prod_ff);
            state_in    = ST_PREP;
         end
         ST_PREP: begin
            // Pick the time source and launch the matching division.
            from_sntp_in = sntp_en_ff && (sntp_base_ff != '0);
            if (from_sntp_in) begin
               base_sel_in  = sntp_base_ff + crst_pkg::crst_tz_seconds(tz_ff);
               div_dividend = ds_ff;
            end else begin
               base_sel_in  = time_base_ff;
               div_dividend = ns_total_ff;
            end
            div_ctl.start  = 1'b1;
            div_ctl.use_ns = !from_sntp_in;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the item to the output register once it is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_stamp_in  = base_sel_ff + div_rsp.quotient;
               rsp_source_in = from_sntp_ff;
               rsp_send_in   = send_ff;
               rsp_sent_in   = sent_ff;
               rsp_recv_in   = recv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sntp_en_ff      <= 1'b0;
         tz_ff           <= '0;
         burst_ff        <= crst_pkg::BURST_POLL_RESET;
         regular_ff      <= crst_pkg::REGULAR_POLL_RESET;
         rtc_last_ff     <= '0;
         ns_total_ff     <= '0;
         wrap_cnt_ff     <= '0;
         time_base_ff    <= '0;
         sntp_base_ff    <= '0;
         ds_ff           <= '0;
         poll_wait_ff    <= '0;
         regular_mode_ff <= 1'b0;
         sent_ff         <= '0;
         recv_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sntp_en_ff      <= sntp_en_in;
         tz_ff           <= tz_in;
         burst_ff        <= burst_in;
         regular_ff      <= regular_in;
         rtc_last_ff     <= rtc_last_in;
         ns_total_ff     <= ns_total_in;
         wrap_cnt_ff     <= wrap_cnt_in;
         time_base_ff    <= time_base_in;
         sntp_base_ff    <= sntp_base_in;
         ds_ff           <= ds_in;
         poll_wait_ff    <= poll_wait_in;
         regular_mode_ff <= regular_mode_in;
         sent_ff         <= sent_in;
         recv_ff         <= recv_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      send_ff       <= send_in;
      from_sntp_ff  <= from_sntp_in;
      cal_ff        <= cal_in;
      diff_ff       <= diff_in;
      scale_ff      <= scale_in;
      prod_ff       <= prod_in;
      base_sel_ff   <= base_sel_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_source_ff <= rsp_source_in;
      rsp_send_ff   <= rsp_send_in;
      rsp_sent_ff   <= rsp_sent_in;
      rsp_recv_ff   <= rsp_recv_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stamp_seconds    = rsp_stamp_ff;
   assign rsp_source_sntp      = rsp_source_ff;
   assign rsp_send_request     = rsp_send_ff;
   assign rsp_requests_sent    = rsp_sent_ff;
   assign rsp_replies_received = rsp_recv_ff;

   // An accepted item always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start the sequencer");

   // A new result appears only out of the final sequencer step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the final step");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished while not awaited");

endmodule

// File: hw/rtl/crst_div.sv
// Division by ten or by one billion through reciprocal multiplication on one 32x32 multiplier.
module crst_div (
   input  logic                         clock,
   input  logic                         reset,
   input  crst_pkg::crst_div_ctl_type   ctl,
   input  logic [crst_pkg::DIV_W-1:0]   dividend,
   output crst_pkg::crst_div_rsp_type   rsp
);

   typedef enum logic [2:0] {
      STEP_LO_LO,
      STEP_LO_HI,
      STEP_HI_LO,
      STEP_HI_HI,
      STEP_BACK_LO,
      STEP_BACK_HI,
      STEP_FIX
   } step_type;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          use_ns_ff, use_ns_in;
   step_type                      step_ff, step_in;
   logic [crst_pkg::DIV_W-1:0]    x_ff, x_in;
   logic [127:0]                  acc_ff, acc_in;
   logic [63:0]                   back_ff, back_in;
   logic [crst_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [31:0]                   divisor;
   logic [63:0]                   recip;
   logic [63:0]                   q_est;
   logic [63:0]                   rem;
   logic [31:0]                   mul_a;
   logic [31:0]                   mul_b;
   logic [63:0]                   prod;

   // Divisor and its reciprocal follow the selection latched at start.
   assign divisor = use_ns_ff ? 32'(crst_pkg::NS_PER_SECOND) : 32'(crst_pkg::DS_PER_SECOND);
   assign recip   = use_ns_ff ? crst_pkg::RECIP_NS : crst_pkg::RECIP_DS;

   // The estimate is the high half of dividend times reciprocal; it is low by at most one.
   assign q_est = acc_ff[127:64];
   assign rem   = x_ff - back_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = x_ff[31:0];
      mul_b = recip[31:0];
      case (step_ff)
         STEP_LO_LO: begin
            mul_a = x_ff[31:0];
            mul_b = recip[31:0];
         end
         STEP_LO_HI: begin
            mul_a = x_ff[31:0];
            mul_b = recip[63:32];
         end
         STEP_HI_LO: begin
            mul_a = x_ff[63:32];
            mul_b = recip[31:0];
         end
         STEP_HI_HI: begin
            mul_a = x_ff[63:32];
            mul_b = recip[63:32];
         end
         STEP_BACK_LO: begin
            mul_a = q_est[31:0];
            mul_b = divisor;
         end
         STEP_BACK_HI: begin
            mul_a = q_est[63:32];
            mul_b = divisor;
         end
         default: ;
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   // Sequencer: four partial products, estimate times divisor, one correction.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      use_ns_in = use_ns_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      back_in   = back_ff;
      quo_in    = quo_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         use_ns_in = ctl.use_ns;
         step_in   = STEP_LO_LO;
         x_in      = dividend;
         acc_in    = '0;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_LO_LO: begin
               acc_in  = acc_ff + 128'(prod);
               step_in = STEP_LO_HI;
            end
            STEP_LO_HI: begin
               acc_in  = acc_ff + {32'd0, prod, 32'd0};
               step_in = STEP_HI_LO;
            end
            STEP_HI_LO: begin
               acc_in  = acc_ff + {32'd0, prod, 32'd0};
               step_in = STEP_HI_HI;
            end
            STEP_HI_HI: begin
               acc_in  = acc_ff + {prod, 64'd0};
               step_in = STEP_BACK_LO;
            end
            STEP_BACK_LO: begin
               back_in = prod;
               step_in = STEP_BACK_HI;
            end
            STEP_BACK_HI: begin
               // Only the low 64 bits of the estimate times the divisor matter.
               back_in = back_ff + {prod[31:0], 32'd0};
               step_in = STEP_FIX;
            end
            STEP_FIX: begin
               quo_in  = q_est + {63'd0, (rem >= 64'(divisor))};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      use_ns_ff <= use_ns_in;
      step_ff   <= step_in;
      x_ff      <= x_in;
      acc_ff    <= acc_in;
      back_ff   <= back_in;
      quo_ff    <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   // The remainder of the estimate stays below twice the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == STEP_FIX) |-> rem < 64'({divisor, 1'b0}))
      else $error("divider estimate off by more than one");

   // Completion only follows a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   // A new division never starts on top of a running one.
   assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule
